FILE: src/srfp_pkg.sv
// Package for the slot run feature packer.
// Holds the run size constants, chunk flag codes and the controller/datapath
// command and status structs. No dependencies.
`default_nettype none

package srfp_pkg;

    localparam int MAX_RUN = 32;
    localparam int IDX_W   = $clog2(MAX_RUN);
    localparam int CNT_W   = $clog2(MAX_RUN + 1);

    localparam logic [7:0] FLAG_HOT_MULTI   = 8'h10;
    localparam logic [7:0] FLAG_COLD_SINGLE = 8'h20;
    localparam logic [7:0] FLAG_COLD_MULTI  = 8'h30;

    localparam logic KIND_HOT  = 1'b0;
    localparam logic KIND_COLD = 1'b1;

    localparam logic [3:0] BYTES_HOT_SINGLE  = 4'd2;
    localparam logic [3:0] BYTES_COLD_SINGLE = 4'd3;
    localparam logic [3:0] BYTES_MULTI       = 4'd4;
    localparam logic [3:0] BYTES_HOT_SIGN    = 4'd4;
    localparam logic [3:0] BYTES_COLD_SIGN   = 4'd8;

    typedef struct packed {
        logic load_in;     // latch the accepted feature
        logic store;       // append the latched sign to the open run
        logic emit_hdr;    // load the run header into the output register
        logic emit_sign;   // load the current sign chunk into the output register
        logic sign_last;   // the sign chunk being emitted closes the run
        logic chunk_last;  // last chunk caused by this feature
        logic chunk_done;  // last chunk of the record
    } srfp_cmd_t;

    typedef struct packed {
        logic need_close;  // the offered feature closes the open run
        logic in_eor;      // latched feature ends the record
        logic idx_last;    // sign index points at the last sign of the run
        logic out_free;    // output register can take a chunk this cycle
    } srfp_status_t;

endpackage

`default_nettype wire

FILE: src/srfp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srfp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/srfp_ctrl.sv
// Controller state machine for the slot run feature packer.
// Sequences feature intake, run closing and chunk emission. Uses srfp_pkg.
`default_nettype none

module srfp_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire srfp_pkg::srfp_status_t status,
    output srfp_pkg::srfp_cmd_t        cmd
);
    import srfp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_SIGN,
        ST_STORE
    } state_t;

    state_t state_reg, state_next;
    logic   eor_phase_reg, eor_phase_next;
    logic   s_ready_reg, s_ready_next;
    logic   accept;

    assign accept  = s_valid && s_ready_reg;
    assign s_ready = s_ready_reg;

    always_comb begin
        state_next     = state_reg;
        eor_phase_next = eor_phase_reg;
        s_ready_next   = s_ready_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_in    = 1'b1;
                    eor_phase_next = 1'b0;
                    s_ready_next   = 1'b0;
                    state_next     = status.need_close ? ST_HDR : ST_STORE;
                end
            end
            ST_HDR: begin
                if (status.out_free) begin
                    cmd.emit_hdr = 1'b1;
                    state_next   = ST_SIGN;
                end
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.emit_sign = 1'b1;
                    if (status.idx_last) begin
                        cmd.sign_last = 1'b1;
                        // The first close ends the results only when no
                        // end-of-record close follows it.
                        cmd.chunk_last = eor_phase_reg || !status.in_eor;
                        cmd.chunk_done = eor_phase_reg;
                        if (eor_phase_reg) begin
                            state_next   = ST_IDLE;
                            s_ready_next = 1'b1;
                        end else begin
                            state_next = ST_STORE;
                        end
                    end
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (status.in_eor) begin
                    eor_phase_next = 1'b1;
                    state_next     = ST_HDR;
                end else begin
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                end
            end
            default: begin
                state_next   = ST_IDLE;
                s_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            eor_phase_reg <= 1'b0;
            s_ready_reg   <= 1'b1;
        end else begin
            state_reg     <= state_next;
            eor_phase_reg <= eor_phase_next;
            s_ready_reg   <= s_ready_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/srfp_datapath.sv
// Datapath for the slot run feature packer: input latch, open run state,
// sign buffer, chunk formatting and the output register.
// Uses srfp_pkg and srfp_ram.
`default_nettype none

module srfp_datapath (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_kind,
    input  wire logic [15:0]            s_slot,
    input  wire logic [63:0]            s_sign,
    input  wire logic                   s_end_of_record,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [63:0]            m_chunk_data,
    output logic      [3:0]             m_chunk_bytes,
    output logic                        m_record_done,
    output logic                        m_last_of_input,
    input  wire srfp_pkg::srfp_cmd_t    cmd,
    output srfp_pkg::srfp_status_t      status
);
    import srfp_pkg::*;

    // Latched feature.
    logic             in_kind_reg;
    logic [15:0]      in_slot_reg;
    logic [63:0]      in_sign_reg;
    logic             in_eor_reg;

    // Open run.
    logic             run_kind_reg, run_kind_next;
    logic [15:0]      run_slot_reg, run_slot_next;
    logic [CNT_W-1:0] run_count_reg, run_count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // Output register.
    logic             m_valid_reg, m_valid_next;
    logic [63:0]      data_reg;
    logic [3:0]       bytes_reg;
    logic             done_reg;
    logic             last_reg;

    logic [63:0]      ram_rdata;
    logic [63:0]      hdr_data;
    logic [3:0]       hdr_bytes;
    logic [63:0]      sign_data;
    logic [3:0]       sign_bytes;
    logic [7:0]       count_byte;
    logic             multi;

    srfp_ram #(
        .WIDTH (64),
        .DEPTH (MAX_RUN)
    ) u_signs (
        .aclk  (aclk),
        .we    (cmd.store),
        .waddr (run_count_reg[IDX_W-1:0]),
        .wdata (in_sign_reg),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    assign status.need_close = (run_count_reg != '0) &&
        ((s_kind != run_kind_reg) || (s_slot != run_slot_reg) ||
         (run_count_reg >= CNT_W'(MAX_RUN)));
    assign status.in_eor   = in_eor_reg;
    assign status.idx_last = ({1'b0, idx_reg} + CNT_W'(1)) == run_count_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign count_byte = 8'(run_count_reg);
    assign multi      = run_count_reg > CNT_W'(1);

    always_comb begin
        hdr_data = {48'd0, run_slot_reg};
        if (run_kind_reg == KIND_HOT) begin
            if (multi) begin
                hdr_data  = {32'd0, count_byte, FLAG_HOT_MULTI, run_slot_reg};
                hdr_bytes = BYTES_MULTI;
            end else begin
                hdr_bytes = BYTES_HOT_SINGLE;
            end
        end else begin
            if (multi) begin
                hdr_data  = {32'd0, count_byte, FLAG_COLD_MULTI, run_slot_reg};
                hdr_bytes = BYTES_MULTI;
            end else begin
                hdr_data  = {40'd0, FLAG_COLD_SINGLE, run_slot_reg};
                hdr_bytes = BYTES_COLD_SINGLE;
            end
        end
    end

    // Hot signs go out big-endian in four bytes, cold signs as stored.
    always_comb begin
        if (run_kind_reg == KIND_HOT) begin
            sign_data  = {32'd0, ram_rdata[7:0], ram_rdata[15:8],
                          ram_rdata[23:16], ram_rdata[31:24]};
            sign_bytes = BYTES_HOT_SIGN;
        end else begin
            sign_data  = ram_rdata;
            sign_bytes = BYTES_COLD_SIGN;
        end
    end

    // The read address runs one step ahead so that the registered read data
    // always belongs to the current sign index.
    always_comb begin
        idx_next = idx_reg;
        if (cmd.emit_hdr) begin
            idx_next = '0;
        end else if (cmd.emit_sign) begin
            idx_next = cmd.sign_last ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        run_kind_next  = run_kind_reg;
        run_slot_next  = run_slot_reg;
        run_count_next = run_count_reg;
        if (cmd.store) begin
            if (run_count_reg == '0) begin
                run_kind_next = in_kind_reg;
                run_slot_next = in_slot_reg;
            end
            run_count_next = run_count_reg + CNT_W'(1);
        end else if (cmd.emit_sign && cmd.sign_last) begin
            run_count_next = '0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit_hdr || cmd.emit_sign) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_kind_reg  <= 1'b0;
            run_slot_reg  <= '0;
            run_count_reg <= '0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            run_kind_reg  <= run_kind_next;
            run_slot_reg  <= run_slot_next;
            run_count_reg <= run_count_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_kind_reg <= s_kind;
            in_slot_reg <= s_slot;
            in_sign_reg <= (s_kind == KIND_HOT) ? {32'd0, s_sign[31:0]} : s_sign;
            in_eor_reg  <= s_end_of_record;
        end
        if (cmd.emit_hdr) begin
            data_reg  <= hdr_data;
            bytes_reg <= hdr_bytes;
            done_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end else if (cmd.emit_sign) begin
            data_reg  <= sign_data;
            bytes_reg <= sign_bytes;
            done_reg  <= cmd.chunk_done;
            last_reg  <= cmd.chunk_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_chunk_data    = data_reg;
    assign m_chunk_bytes   = bytes_reg;
    assign m_record_done   = done_reg;
    assign m_last_of_input = last_reg;

endmodule

`default_nettype wire

FILE: src/slot_run_feature_packer_unit.sv
// Top level of the slot run feature packer.
// Joins the controller (srfp_ctrl) and the datapath (srfp_datapath); uses srfp_pkg.
//
//   Channel   Direction  Ports                                              Transaction
//   input     in         s_valid/s_ready, s_kind, s_slot, s_sign,           one feature
//                        s_end_of_record
//   result    out        m_valid/m_ready, m_chunk_data, m_chunk_bytes,      one chunk
//                        m_record_done, m_last_of_input
//
// A feature that extends the open run is accepted, then written to the sign buffer.
// Closing a run of N signs emits a header chunk and N sign chunks, one chunk per cycle out of the
// sign buffer while the result channel does not stall; an end-of-record feature adds a close of its own.
// Reset (aresetn, synchronous, active low) empties the run; the sign buffer is not cleared.
// A stalled result channel holds the controller until the output register frees.
`default_nettype none

module slot_run_feature_packer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [15:0] s_slot,
    input  wire logic [63:0] s_sign,
    input  wire logic        s_end_of_record,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [63:0] m_chunk_data,
    output logic      [3:0]  m_chunk_bytes,
    output logic             m_record_done,
    output logic             m_last_of_input
);
    import srfp_pkg::*;

    srfp_cmd_t    cmd;
    srfp_status_t status;

    srfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    srfp_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_kind          (s_kind),
        .s_slot          (s_slot),
        .s_sign          (s_sign),
        .s_end_of_record (s_end_of_record),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chunk_data    (m_chunk_data),
        .m_chunk_bytes   (m_chunk_bytes),
        .m_record_done   (m_record_done),
        .m_last_of_input (m_last_of_input),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

`default_nettype wire

FILE: src/srfp_checker.sv
// Port-level checker for slot_run_feature_packer_unit, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module srfp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_chunk_data,
    input wire logic [3:0]  m_chunk_bytes,
    input wire logic        m_record_done,
    input wire logic        m_last_of_input
);

    // A stalled chunk keeps its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chunk_data))
        else $error("result chunk changed while stalled");

    // One feature is worked on at a time.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again right after a transaction");

    a_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_chunk_bytes >= 4'd2) && (m_chunk_bytes <= 4'd8))
        else $error("chunk byte count out of range");

    // The record's final chunk also ends its feature's results.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_record_done |-> m_last_of_input)
        else $error("record end without last-of-input");

    a_hot_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_chunk_bytes == 4'd2) |-> (m_chunk_data[63:16] == 48'd0))
        else $error("bytes above a two-byte header are not zero");

endmodule

bind slot_run_feature_packer_unit srfp_checker u_srfp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_chunk_data    (m_chunk_data),
    .m_chunk_bytes   (m_chunk_bytes),
    .m_record_done   (m_record_done),
    .m_last_of_input (m_last_of_input)
);

`default_nettype wire

FILE: tb/sv/tb_slot_run_feature_packer_unit.sv
// Self-checking testbench for slot_run_feature_packer_unit.
// Predicts the packed chunk stream of each accepted feature and checks the result channel.
// Depends on srfp_pkg and the packer RTL only.

module tb_slot_run_feature_packer_unit;

    import srfp_pkg::*;

    localparam int RANDOM_ITEMS = 350;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        logic        kind;
        logic [15:0] slot;
        logic [63:0] sign;
        logic        eor;
    } feature_t;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        done;
        logic        last_in;
    } chunk_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    feature_t    offer   = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_chunk_data;
    logic [3:0]  m_chunk_bytes;
    logic        m_record_done;
    logic        m_last_of_input;

    feature_t pending_features[$];
    chunk_t   chunks_due[$];
    chunk_t   step_chunks[$];

    // Packer state as the predictor sees it.
    logic [63:0]      open_signs [MAX_RUN];
    logic [15:0]      open_slot = '0;
    logic             open_kind = KIND_HOT;
    logic [CNT_W-1:0] open_len  = '0;

    int mismatches  = 0;
    int cycles      = 0;
    int offer_gap   = 0;
    int ready_hold  = 0;
    int source_calm = 0;
    int sink_calm   = 0;

    always #10 aclk = ~aclk;

    slot_run_feature_packer_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (offer.kind),
        .s_slot          (offer.slot),
        .s_sign          (offer.sign),
        .s_end_of_record (offer.eor),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chunk_data    (m_chunk_data),
        .m_chunk_bytes   (m_chunk_bytes),
        .m_record_done   (m_record_done),
        .m_last_of_input (m_last_of_input)
    );

    function automatic chunk_t make_chunk(input logic [63:0] data, input logic [3:0] nbytes);
        chunk_t c;
        c.data    = data;
        c.nbytes  = nbytes;
        c.done    = 1'b0;
        c.last_in = 1'b0;
        return c;
    endfunction

    // Emits the open run as a header chunk followed by one chunk per sign.
    function automatic void flush_open_run();
        logic [63:0] hdr;
        logic [63:0] s;
        int          i;
        if (open_len != 0) begin
            hdr = {48'b0, open_slot};
            if (open_len > 1) begin
                hdr[23:16] = (open_kind == KIND_HOT) ? FLAG_HOT_MULTI : FLAG_COLD_MULTI;
                hdr[31:24] = 8'(open_len);
                step_chunks.insert(step_chunks.size(), make_chunk(hdr, BYTES_MULTI));
            end else if (open_kind == KIND_HOT) begin
                step_chunks.insert(step_chunks.size(), make_chunk(hdr, BYTES_HOT_SINGLE));
            end else begin
                hdr[23:16] = FLAG_COLD_SINGLE;
                step_chunks.insert(step_chunks.size(), make_chunk(hdr, BYTES_COLD_SINGLE));
            end
            for (i = 0; i < open_len; i++) begin
                s = open_signs[i];
                if (open_kind == KIND_HOT) begin
                    step_chunks.insert(step_chunks.size(),
                                       make_chunk({32'b0, s[7:0], s[15:8], s[23:16], s[31:24]},
                                                  BYTES_HOT_SIGN));
                end else begin
                    step_chunks.insert(step_chunks.size(), make_chunk(s, BYTES_COLD_SIGN));
                end
            end
            open_len = '0;
        end
    endfunction

    // Advances the predicted packer state by one feature and queues the chunks it causes.
    function automatic void pack_feature(input feature_t f);
        logic [63:0] s;
        step_chunks.delete();
        if (open_len != 0 &&
            (f.kind != open_kind || f.slot != open_slot || open_len >= MAX_RUN)) begin
            flush_open_run();
        end
        if (open_len == 0) begin
            open_kind = f.kind;
            open_slot = f.slot;
        end
        s = (f.kind == KIND_HOT) ? {32'b0, f.sign[31:0]} : f.sign;
        if (open_len < MAX_RUN) begin
            open_signs[open_len] = s;
            open_len++;
        end
        if (f.eor) begin
            flush_open_run();
            if (step_chunks.size() > 0) begin
                step_chunks[step_chunks.size() - 1].done = 1'b1;
            end
        end
        if (step_chunks.size() > 0) begin
            step_chunks[step_chunks.size() - 1].last_in = 1'b1;
        end
        foreach (step_chunks[k]) begin
            chunks_due.insert(chunks_due.size(), step_chunks[k]);
        end
    endfunction

    // Wait draw with occasional stretches of back-to-back traffic.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(10, 40);
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [15:0] pick_slot();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_run_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 1;
        if (r < 16) return $urandom_range(2, 5);
        if (r == 16) return MAX_RUN;
        if (r == 17) return MAX_RUN + 1;
        if (r == 18) return $urandom_range(6, MAX_RUN - 1);
        return 2 * MAX_RUN + 1;
    endfunction

    task automatic queue_run(input logic kind, input logic [15:0] slot, input int len,
                             input logic closes_record);
        feature_t f;
        int       i;
        for (i = 0; i < len; i++) begin
            f.kind = kind;
            f.slot = slot;
            f.sign = {$urandom, $urandom};
            f.eor  = closes_record && (i == len - 1);
            pending_features.insert(pending_features.size(), f);
        end
    endtask

    initial begin : stimulus
        feature_t    f;
        int          directed_count;
        int          n;
        int          hot_runs;
        int          cold_runs;
        int          k;
        logic [15:0] slot;

        // Hot single with the unused upper sign bits set, cold singles at the slot extremes, then a hot single.
        f = '{kind: KIND_HOT, slot: 16'h0000, sign: 64'hFFFF_FFFF_FFFF_FFFF, eor: 1'b1};
        pending_features.insert(pending_features.size(), f);
        f = '{kind: KIND_COLD, slot: 16'hFFFF, sign: 64'hFFFF_FFFF_FFFF_FFFF, eor: 1'b1};
        pending_features.insert(pending_features.size(), f);
        f = '{kind: KIND_COLD, slot: 16'h0000, sign: 64'h0, eor: 1'b1};
        pending_features.insert(pending_features.size(), f);
        f = '{kind: KIND_HOT, slot: 16'hFFFF, sign: 64'h0123_4567_89AB_CDEF, eor: 1'b1};
        pending_features.insert(pending_features.size(), f);
        // Hot multi, cold multi on the same slot, then a cold single.
        queue_run(KIND_HOT, 16'h1234, 3, 1'b0);
        queue_run(KIND_COLD, 16'h1234, 2, 1'b0);
        queue_run(KIND_COLD, 16'hABCD, 1, 1'b1);
        // A hot feature after a cold one closes the cold run like any kind change.
        queue_run(KIND_COLD, 16'h0007, 1, 1'b0);
        queue_run(KIND_HOT, 16'h0007, 1, 1'b1);
        // A full run followed by one more feature of the same slot ending the record.
        queue_run(KIND_HOT, 16'h00FF, MAX_RUN + 1, 1'b1);
        directed_count = pending_features.size();

        while (pending_features.size() < directed_count + RANDOM_ITEMS) begin
            if ($urandom_range(0, 6) == 0) begin
                // Disordered record: kinds mixed freely over a few slots.
                n = $urandom_range(1, 12);
                for (k = 0; k < n; k++) begin
                    f.kind = 1'($urandom_range(0, 1));
                    f.slot = 16'($urandom_range(0, 3));
                    f.sign = {$urandom, $urandom};
                    f.eor  = (k == n - 1);
                    pending_features.insert(pending_features.size(), f);
                end
            end else begin
                hot_runs  = $urandom_range(0, 3);
                cold_runs = $urandom_range(0, 3);
                if (hot_runs + cold_runs == 0) begin
                    hot_runs = 1;
                end
                slot = pick_slot();
                for (k = 0; k < hot_runs + cold_runs; k++) begin
                    if ($urandom_range(0, 3) != 0) begin
                        slot = pick_slot();
                    end
                    queue_run((k < hot_runs) ? KIND_HOT : KIND_COLD, slot, pick_run_len(),
                              k == hot_runs + cold_runs - 1);
                end
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (pending_features.size() != 0 || s_valid || chunks_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (2 * MAX_RUN + 16) @(negedge aclk);

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Feature driver: one transaction per pending item, with a random gap after each.
    always @(posedge aclk) begin : source
        int gap;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            offer_gap <= 0;
        end else if (s_valid && s_ready) begin
            pack_feature(offer);
            gap = draw_wait(source_calm);
            if (gap == 0 && pending_features.size() > 0) begin
                offer <= pending_features.pop_front();
            end else begin
                s_valid   <= 1'b0;
                offer_gap <= gap;
            end
        end else if (!s_valid) begin
            if (offer_gap > 0) begin
                offer_gap <= offer_gap - 1;
            end else if (pending_features.size() > 0) begin
                offer   <= pending_features.pop_front();
                s_valid <= 1'b1;
            end
        end
    end

    // Chunk monitor: checks each transaction against the oldest predicted chunk.
    always @(posedge aclk) begin : sink
        chunk_t want;
        int     hold;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (m_valid && m_ready) begin
            if (chunks_due.size() == 0) begin
                $display("%0t: unexpected chunk: expected none, got data %h bytes %0d",
                         $time, m_chunk_data, m_chunk_bytes);
                mismatches++;
            end else begin
                want = chunks_due.pop_front();
                if (m_chunk_data !== want.data) begin
                    $display("%0t: chunk_data mismatch: expected %h, got %h",
                             $time, want.data, m_chunk_data);
                    mismatches++;
                end
                if (m_chunk_bytes !== want.nbytes) begin
                    $display("%0t: chunk_bytes mismatch: expected %0d, got %0d",
                             $time, want.nbytes, m_chunk_bytes);
                    mismatches++;
                end
                if (m_record_done !== want.done) begin
                    $display("%0t: record_done mismatch: expected %b, got %b",
                             $time, want.done, m_record_done);
                    mismatches++;
                end
                if (m_last_of_input !== want.last_in) begin
                    $display("%0t: last_of_input mismatch: expected %b, got %b",
                             $time, want.last_in, m_last_of_input);
                    mismatches++;
                end
            end
            hold = draw_wait(sink_calm);
            ready_hold <= hold;
            m_ready    <= (hold == 0);
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= (ready_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d chunks still expected", $time, chunks_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

FILE: files.f
src/srfp_pkg.sv
src/srfp_ram.sv
src/srfp_ctrl.sv
src/srfp_datapath.sv
src/slot_run_feature_packer_unit.sv
src/srfp_checker.sv
tb/sv/tb_slot_run_feature_packer_unit.sv
